// File: rtl/core/kms_pkg.sv
// ----------------------------------------------------------------------------
// kms_pkg: shared types and constants of the keyboard matrix scanner
// Item kinds, special key codes, column limits and register map.
// ----------------------------------------------------------------------------
package kms_pkg;

  localparam int unsigned KeyW   = 7;
  localparam int unsigned ColW   = 4;
  localparam int unsigned DipW   = 8;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  typedef enum logic [1:0] {
    KindTick    = 2'd0,
    KindPress   = 2'd1,
    KindRelease = 2'd2
  } kind_e;

  // Special query/key codes
  localparam logic [KeyW-1:0] CodeShift = 7'd0;
  localparam logic [KeyW-1:0] CodeCtrl  = 7'd1;
  localparam logic [KeyW-1:0] CodeDipLo = 7'd2;
  localparam logic [KeyW-1:0] CodeDipHi = 7'd9;

  localparam logic [ColW-1:0] LastAnswerCol = 4'd9;
  localparam logic [ColW-1:0] LastModCol    = 4'd14;  // column modulus 15 minus one
  localparam logic [ColW-1:0] ColTop        = 4'd15;

  // Register map (byte addresses)
  localparam logic [AddrW-1:0] RegDipSwitches = 3'd0;

  typedef struct packed {
    logic            vld;
    logic [KeyW-1:0] code;
  } slot_t;

endpackage

// File: rtl/core/keyboard_matrix_scanner_unit.sv
// ----------------------------------------------------------------------------
// keyboard_matrix_scanner_unit: two-key rollover matrix keyboard scanner
// Tracks two held-key slots plus shift/ctrl flags, answers PA7 queries,
// latches LEDs and autoscan, and drives a per-tick column interrupt level.
// ----------------------------------------------------------------------------
// Result: registered, valid in the cycle after its input transfer.
// Throughput: one item per cycle; the single result register frees as it is
//   taken, so a new item is accepted whenever the result is empty or drains.
// Reset: asynchronous, active low; slots empty, flags and LEDs clear,
//   autoscan on, column 0, DIP switches 0, no result pending.
module keyboard_matrix_scanner_unit
  import kms_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  // input channel
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       kind_i,
  input  logic [KeyW-1:0]  key_code_i,
  input  logic             autoscan_line_i,
  input  logic             data_written_i,
  input  logic [KeyW-1:0]  port_data_i,
  input  logic             caps_line_i,
  input  logic             shiftlock_line_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             irq_asserted_o,
  output logic             answer_valid_o,
  output logic [DipW-1:0]  answer_byte_o,
  output logic [ColW-1:0]  column_now_o,
  output logic             caps_led_o,
  output logic             shiftlock_led_o
);

  // --------------------------------------------------------------------------
  // Configuration: DIP switch register, written on the APB access phase
  // --------------------------------------------------------------------------
  logic [DipW-1:0] dip_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr == RegDipSwitches) begin
      prdata = DataW'(dip_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dip_q <= '0;
    end else if (cfg_wr && paddr == RegDipSwitches) begin
      dip_q <= pwdata[DipW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Scanner state
  // --------------------------------------------------------------------------
  logic            autoscan_q, autoscan_d;
  logic [ColW-1:0] col_q, col_d;
  logic            caps_q, caps_d;
  logic            shl_q, shl_d;
  slot_t           k0_q, k0_d;   // first slot
  slot_t           k1_q, k1_d;   // second slot
  logic            shift_q, shift_d;
  logic            ctrl_q, ctrl_d;

  // result register
  logic            out_valid_q;
  logic            irq_q, irq_d;
  logic            ans_vld_q, ans_vld_d;
  logic [DipW-1:0] ans_q, ans_d;

  logic in_xfer;

  // Accept whenever the result register is empty or is being taken.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Single-pass item logic
  // --------------------------------------------------------------------------
  logic            k0_hit, k1_hit;
  logic [ColW-1:0] col_ld;
  logic [2:0]      dip_sel;
  logic            query_set;

  always_comb begin
    autoscan_d = autoscan_q;
    col_d      = col_q;
    caps_d     = caps_q;
    shl_d      = shl_q;
    k0_d       = k0_q;
    k1_d       = k1_q;
    shift_d    = shift_q;
    ctrl_d     = ctrl_q;
    irq_d      = 1'b0;
    ans_vld_d  = 1'b0;
    ans_d      = '0;
    col_ld     = col_q;
    query_set  = 1'b0;

    k0_hit  = k0_q.vld && (k0_q.code == key_code_i);
    k1_hit  = k1_q.vld && (k1_q.code == key_code_i);
    dip_sel = 3'(CodeDipHi - port_data_i);  // DIP bit index for codes 2 to 9

    case (kind_i)
      KindTick: begin
        // latch active-low LED lines and autoscan enable
        caps_d     = !caps_line_i;
        shl_d      = !shiftlock_line_i;
        autoscan_d = autoscan_line_i;

        if (!autoscan_line_i && data_written_i) begin
          col_ld = port_data_i[ColW-1:0];
          if (col_ld <= LastAnswerCol) begin
            ans_vld_d = 1'b1;
            if (port_data_i >= CodeDipLo && port_data_i <= CodeDipHi) begin
              query_set = dip_q[dip_sel];
            end else if (port_data_i == CodeShift) begin
              query_set = shift_q;
            end else if (port_data_i == CodeCtrl) begin
              query_set = ctrl_q;
            end else begin
              query_set = (k0_q.vld && k0_q.code == port_data_i) ||
                          (k1_q.vld && k1_q.code == port_data_i);
            end
            ans_d = query_set ? {1'b1, port_data_i} : '0;
          end
        end

        // interrupt level: a held key lies in the current column
        irq_d = (k0_q.vld && k0_q.code[ColW-1:0] == col_ld) ||
                (k1_q.vld && k1_q.code[ColW-1:0] == col_ld);

        // advance modulo 15
        if (autoscan_line_i) begin
          if (col_ld == LastModCol) begin
            col_d = '0;
          end else if (col_ld == ColTop) begin
            col_d = ColW'(1);
          end else begin
            col_d = col_ld + ColW'(1);
          end
        end else begin
          col_d = col_ld;
        end
      end

      KindPress: begin
        if (key_code_i == CodeShift) begin
          shift_d = 1'b1;
        end else if (key_code_i == CodeCtrl) begin
          ctrl_d = 1'b1;
        end else if (!k0_hit && !k1_hit) begin
          if (!k0_q.vld) begin
            k0_d = '{vld: 1'b1, code: key_code_i};
          end else if (!k1_q.vld) begin
            k1_d = '{vld: 1'b1, code: key_code_i};
          end
        end
      end

      KindRelease: begin
        if (key_code_i == CodeShift) begin
          shift_d = 1'b0;
        end else if (key_code_i == CodeCtrl) begin
          ctrl_d = 1'b0;
        end else if (k0_hit) begin
          // free the first slot, pull the second one forward
          k0_d = k1_q;
          k1_d = '{vld: 1'b0, code: '0};
        end else if (k1_hit) begin
          k1_d = '{vld: 1'b0, code: '0};
        end
      end

      default: begin
        // unused kind: state holds, result is all zero
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      autoscan_q  <= 1'b1;
      col_q       <= '0;
      caps_q      <= 1'b0;
      shl_q       <= 1'b0;
      k0_q        <= '{vld: 1'b0, code: '0};
      k1_q        <= '{vld: 1'b0, code: '0};
      shift_q     <= 1'b0;
      ctrl_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        autoscan_q <= autoscan_d;
        col_q      <= col_d;
        caps_q     <= caps_d;
        shl_q      <= shl_d;
        k0_q       <= k0_d;
        k1_q       <= k1_d;
        shift_q    <= shift_d;
        ctrl_q     <= ctrl_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  // payload of the result register: loaded on each input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      irq_q     <= irq_d;
      ans_vld_q <= ans_vld_d;
      ans_q     <= ans_d;
    end
  end

  // State changes only on input transfers, so these hold while stalled.
  assign out_valid_o     = out_valid_q;
  assign irq_asserted_o  = irq_q;
  assign answer_valid_o  = ans_vld_q;
  assign answer_byte_o   = ans_q;
  assign column_now_o    = col_q;
  assign caps_led_o      = caps_q;
  assign shiftlock_led_o = shl_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The second slot is only occupied while the first one is.
  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k1_q.vld |-> k0_q.vld)
    else $error("second key slot held while first slot empty");

  // Two held slots never carry the same key.
  a_slot_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k0_q.vld && k1_q.vld) |-> (k0_q.code != k1_q.code))
    else $error("same key held in both slots");

  // No answer driven means a zero answer byte.
  a_answer_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !answer_valid_o) |-> (answer_byte_o == '0))
    else $error("answer byte nonzero without an answer");

  // An autoscan tick never leaves the column at fifteen.
  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && kind_i == KindTick && autoscan_line_i) |=> (col_q != ColTop))
    else $error("autoscan column outside modulo range");

endmodule

// File: tb/tb_keyboard_matrix_scanner_unit.sv
// ----------------------------------------------------------------------------
// tb_keyboard_matrix_scanner_unit: self-checking bench for the matrix scanner
// A directed table covers the rollover slots, shift/ctrl, DIP queries and
// column edges. Random phases under several DIP settings follow. Every
// result is checked field by field against its typed row or an in-bench scanner model.
// ----------------------------------------------------------------------------
module tb_keyboard_matrix_scanner_unit;
  import kms_pkg::*;

  // Kind code that the block must ignore
  localparam logic [1:0] KindSpare  = 2'd3;
  localparam logic [7:0] SlotEmpty  = 8'hFF;
  localparam int         ColumnMod  = 15;
  localparam int         PhaseItems = 260;
  localparam int         NumPhases  = 5;
  localparam int         NumDirect  = 26;
  localparam int         CycleLimit = 200000;

  typedef struct packed {
    logic [1:0]      kind;
    logic [KeyW-1:0] key;
    logic            autoscan;
    logic            dw;
    logic [KeyW-1:0] pdata;
    logic            caps;
    logic            shl;
  } scan_in_t;

  typedef struct packed {
    logic            irq;
    logic            ans_vld;
    logic [DipW-1:0] ans;
    logic [ColW-1:0] col;
    logic            caps;
    logic            shl;
  } scan_out_t;

  typedef struct packed {
    scan_in_t  stim;
    logic      typed;
    scan_out_t out;
  } dir_row_t;

  localparam scan_out_t NoOut = '0;

  // --------------------------------------------------------------------------
  // DUT signals, all known from time zero
  // --------------------------------------------------------------------------
  logic             clk_i            = 1'b0;
  logic             rst_ni           = 1'b0;
  logic             psel             = 1'b0;
  logic             penable          = 1'b0;
  logic             pwrite           = 1'b0;
  logic [AddrW-1:0] paddr            = '0;
  logic [DataW-1:0] pwdata           = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i       = 1'b0;
  logic             in_ready_o;
  logic [1:0]       kind_i           = KindTick;
  logic [KeyW-1:0]  key_code_i       = '0;
  logic             autoscan_line_i  = 1'b1;
  logic             data_written_i   = 1'b0;
  logic [KeyW-1:0]  port_data_i      = '0;
  logic             caps_line_i      = 1'b1;
  logic             shiftlock_line_i = 1'b1;
  logic             out_valid_o;
  logic             out_ready_i      = 1'b0;
  logic             irq_asserted_o;
  logic             answer_valid_o;
  logic [DipW-1:0]  answer_byte_o;
  logic [ColW-1:0]  column_now_o;
  logic             caps_led_o;
  logic             shiftlock_led_o;

  keyboard_matrix_scanner_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .key_code_i       (key_code_i),
    .autoscan_line_i  (autoscan_line_i),
    .data_written_i   (data_written_i),
    .port_data_i      (port_data_i),
    .caps_line_i      (caps_line_i),
    .shiftlock_line_i (shiftlock_line_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .irq_asserted_o   (irq_asserted_o),
    .answer_valid_o   (answer_valid_o),
    .answer_byte_o    (answer_byte_o),
    .column_now_o     (column_now_o),
    .caps_led_o       (caps_led_o),
    .shiftlock_led_o  (shiftlock_led_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scanner state as the bench sees it
  // --------------------------------------------------------------------------
  logic [DipW-1:0] kb_dip      = '0;
  logic            kb_autoscan = 1'b1;
  logic [ColW-1:0] kb_col      = '0;
  logic            kb_caps     = 1'b0;
  logic            kb_shlock   = 1'b0;
  logic [7:0]      kb_first    = SlotEmpty;
  logic [7:0]      kb_second   = SlotEmpty;
  logic            kb_shift    = 1'b0;
  logic            kb_ctrl     = 1'b0;

  scan_out_t scan_reports[$];   // results still owed by the block
  int        err_count = 0;
  int        n_results = 0;
  int        cycles    = 0;

  function automatic logic slot_hits(logic [7:0] slot);
    return (slot != SlotEmpty) && (slot[3:0] == kb_col);
  endfunction

  // Apply one item to the scanner state and return the result it causes
  function automatic scan_out_t scan_item(scan_in_t it);
    scan_out_t  r;
    logic [7:0] code8;
    logic [7:0] hit;
    r     = '0;
    code8 = {1'b0, it.key};
    hit   = {1'b1, it.pdata};
    case (it.kind)
      KindTick: begin
        // LED lines are active low
        kb_caps     = !it.caps;
        kb_shlock   = !it.shl;
        kb_autoscan = it.autoscan;
        if (!kb_autoscan && it.dw) begin
          kb_col = it.pdata[3:0];
          if (kb_col <= LastAnswerCol) begin
            r.ans_vld = 1'b1;
            if (it.pdata >= CodeDipLo && it.pdata <= CodeDipHi) begin
              // DIP 0 answers on the highest code
              r.ans = kb_dip[3'(CodeDipHi - it.pdata)] ? hit : 8'h00;
            end else if (it.pdata == CodeShift) begin
              r.ans = kb_shift ? hit : 8'h00;
            end else if (it.pdata == CodeCtrl) begin
              r.ans = kb_ctrl ? hit : 8'h00;
            end else if (kb_first == {1'b0, it.pdata} || kb_second == {1'b0, it.pdata}) begin
              r.ans = hit;
            end
          end
        end
        r.irq = slot_hits(kb_first) || slot_hits(kb_second);
        if (kb_autoscan) begin
          kb_col = 4'((int'(kb_col) + 1) % ColumnMod);
        end
      end
      KindPress: begin
        if (it.key == CodeShift) begin
          kb_shift = 1'b1;
        end else if (it.key == CodeCtrl) begin
          kb_ctrl = 1'b1;
        end else if (kb_first != code8 && kb_second != code8) begin
          if (kb_first == SlotEmpty) begin
            kb_first = code8;
          end else if (kb_second == SlotEmpty) begin
            kb_second = code8;
          end
        end
      end
      KindRelease: begin
        if (it.key == CodeShift) begin
          kb_shift = 1'b0;
        end else if (it.key == CodeCtrl) begin
          kb_ctrl = 1'b0;
        end else if (kb_first == code8) begin
          // second slot moves up into the first
          kb_first  = kb_second;
          kb_second = SlotEmpty;
        end else if (kb_second == code8) begin
          kb_second = SlotEmpty;
        end
      end
      default: ;
    endcase
    r.col  = kb_col;
    r.caps = kb_caps;
    r.shl  = kb_shlock;
    return r;
  endfunction

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    err_count++;
    $display("mismatch on %s: got %0h, want %0h (result %0d)", what, got, want, n_results);
  endtask

  // --------------------------------------------------------------------------
  // Result side: check each transfer, stall on a pattern of its own
  // --------------------------------------------------------------------------
  scan_out_t  want;
  logic [7:0] hold_pat = 8'hFF;
  int         pat_age  = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (scan_reports.size() == 0) begin
          flag_mismatch("result with none pending", 1, 0);
        end else begin
          want = scan_reports.pop_front();
          if (irq_asserted_o !== want.irq)
            flag_mismatch("irq_asserted", irq_asserted_o, want.irq);
          if (answer_valid_o !== want.ans_vld)
            flag_mismatch("answer_valid", answer_valid_o, want.ans_vld);
          if (answer_byte_o !== want.ans)
            flag_mismatch("answer_byte", answer_byte_o, want.ans);
          if (column_now_o !== want.col)
            flag_mismatch("column_now", column_now_o, want.col);
          if (caps_led_o !== want.caps)
            flag_mismatch("caps_led", caps_led_o, want.caps);
          if (shiftlock_led_o !== want.shl)
            flag_mismatch("shiftlock_led", shiftlock_led_o, want.shl);
        end
      end
      // Reload the pattern now and then; one window in four never stalls,
      // and bit 0 forced high bounds the length of each stall
      if (pat_age == 0) begin
        hold_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        pat_age  = $urandom_range(16, 80);
      end else begin
        pat_age--;
      end
      hold_pat = {hold_pat[0], hold_pat[7:1]};
      out_ready_i <= hold_pat[0];
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  int burst_left = 1;

  // Close a burst after the last transfer, drop valid for a random gap
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Present one item, hold it until the transfer, then log its result
  task automatic transfer_item(scan_in_t it, logic typed, scan_out_t typed_out);
    scan_out_t got;
    in_valid_i       <= 1'b1;
    kind_i           <= it.kind;
    key_code_i       <= it.key;
    autoscan_line_i  <= it.autoscan;
    data_written_i   <= it.dw;
    port_data_i      <= it.pdata;
    caps_line_i      <= it.caps;
    shiftlock_line_i <= it.shl;
    do @(posedge clk_i); while (!in_ready_o);
    got = scan_item(it);
    scan_reports.push_back(typed ? typed_out : got);
    pace_sender();
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (scan_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the DIP register (setup then access), then read it back
  task automatic write_dip(logic [DipW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegDipSwitches;
    pwdata  <= {{(DataW-DipW){1'b0}}, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    kb_dip = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {{(DataW-DipW){1'b0}}, v})
      flag_mismatch("dip readback", prdata, v);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Directed table: DIP holds 8'h81 while it runs. Rows with a typed result
  // are the ones readable by eye; the rest go through the scanner model.
  // Fields: kind, key, autoscan, data_written, port_data, caps, shiftlock
  // --------------------------------------------------------------------------
  dir_row_t directed_rows [NumDirect] = '{
    // first tick after reset: LEDs off, column advances to 1
    '{'{KindTick, 7'h00, 1'b1, 1'b0, 7'h00, 1'b1, 1'b1}, 1'b1,
      '{1'b0, 1'b0, 8'h00, 4'd1, 1'b0, 1'b0}},
    // top key code fills the first slot
    '{'{KindPress, 7'h7F, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 8'h00, 4'd1, 1'b0, 1'b0}},
    // shift and ctrl only set their flags
    '{'{KindPress, CodeShift, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 8'h00, 4'd1, 1'b0, 1'b0}},
    '{'{KindPress, CodeCtrl, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 8'h00, 4'd1, 1'b0, 1'b0}},
    // second slot, then a press with both full, then a repeat press
    '{'{KindPress, 7'h23, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0}, 1'b0, NoOut},
    '{'{KindPress, 7'h45, 1'b1, 1'b1, 7'h7F, 1'b1, 1'b1}, 1'b0, NoOut},
    '{'{KindPress, 7'h7F, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0}, 1'b0, NoOut},
    // queries with autoscan off: shift, ctrl, DIP 0, DIP 7
    '{'{KindTick, 7'h00, 1'b0, 1'b1, CodeShift, 1'b0, 1'b0}, 1'b1,
      '{1'b0, 1'b1, 8'h80, 4'd0, 1'b1, 1'b1}},
    '{'{KindTick, 7'h00, 1'b0, 1'b1, CodeCtrl, 1'b0, 1'b0}, 1'b1,
      '{1'b0, 1'b1, 8'h81, 4'd1, 1'b1, 1'b1}},
    '{'{KindTick, 7'h00, 1'b0, 1'b1, CodeDipHi, 1'b1, 1'b0}, 1'b1,
      '{1'b0, 1'b1, 8'h89, 4'd9, 1'b0, 1'b1}},
    '{'{KindTick, 7'h00, 1'b0, 1'b1, CodeDipLo, 1'b1, 1'b1}, 1'b1,
      '{1'b0, 1'b1, 8'h82, 4'd2, 1'b0, 1'b0}},
    // clear DIP bit, then a hit on the second slot with its column
    '{'{KindTick, 7'h00, 1'b0, 1'b1, 7'h05, 1'b1, 1'b1}, 1'b0, NoOut},
    '{'{KindTick, 7'h00, 1'b0, 1'b1, 7'h23, 1'b1, 1'b1}, 1'b0, NoOut},
    // column above nine: no answer, held key in column 15 raises irq
    '{'{KindTick, 7'h00, 1'b0, 1'b1, 7'h7F, 1'b1, 1'b1}, 1'b1,
      '{1'b1, 1'b0, 8'h00, 4'd15, 1'b0, 1'b0}},
    // autoscan from column 15 wraps to 1
    '{'{KindTick, 7'h00, 1'b1, 1'b0, 7'h00, 1'b1, 1'b1}, 1'b1,
      '{1'b1, 1'b0, 8'h00, 4'd1, 1'b0, 1'b0}},
    '{'{KindTick, 7'h00, 1'b0, 1'b0, 7'h00, 1'b1, 1'b1}, 1'b0, NoOut},
    // release first slot shifts the second up; release of unheld key
    '{'{KindRelease, 7'h7F, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0}, 1'b0, NoOut},
    '{'{KindRelease, 7'h45, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0}, 1'b0, NoOut},
    '{'{KindRelease, CodeShift, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0}, 1'b0, NoOut},
    '{'{KindTick, 7'h00, 1'b0, 1'b1, CodeShift, 1'b0, 1'b1}, 1'b0, NoOut},
    // unused kind changes nothing
    '{'{KindSpare, 7'h7F, 1'b1, 1'b1, 7'h7F, 1'b1, 1'b1}, 1'b0, NoOut},
    // release of the second slot
    '{'{KindPress, 7'h33, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0}, 1'b0, NoOut},
    '{'{KindRelease, 7'h33, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0}, 1'b0, NoOut},
    '{'{KindRelease, 7'h23, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0}, 1'b0, NoOut},
    '{'{KindTick, 7'h00, 1'b0, 1'b1, 7'h23, 1'b0, 1'b0}, 1'b0, NoOut},
    // data written under autoscan must not load the column
    '{'{KindTick, 7'h00, 1'b1, 1'b1, 7'h07, 1'b1, 1'b0}, 1'b0, NoOut}
  };

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  logic [DipW-1:0] dip_plan [NumPhases];
  logic [KeyW-1:0] key_pool [6];

  initial begin
    scan_in_t it;
    int       r;
    // Hold reset, then release it at a rising edge
    repeat (12) @(posedge clk_i);
    rst_ni      <= 1'b1;
    out_ready_i <= 1'b1;
    @(posedge clk_i);

    write_dip(8'h81);
    foreach (directed_rows[i]) begin
      transfer_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].out);
    end

    dip_plan = '{8'h00, 8'hFF, 8'($urandom), 8'h5A, 8'($urandom)};
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      write_dip(dip_plan[ph]);
      // Fresh set of keys per phase so presses, releases and queries collide
      foreach (key_pool[k]) key_pool[k] = 7'($urandom_range(0, 127));
      for (int n = 0; n < PhaseItems; n++) begin
        // Mid-run pause: let every owed result come back first
        if (ph == 2 && n == PhaseItems / 2) drain_results();
        it.key      = 7'($urandom);
        it.pdata    = 7'($urandom);
        it.autoscan = ($urandom_range(0, 9) < 4);
        it.dw       = ($urandom_range(0, 9) < 7);
        it.caps     = 1'($urandom);
        it.shl      = 1'($urandom);
        r = $urandom_range(0, 99);
        if (r < 45)       it.kind = KindTick;
        else if (r < 72)  it.kind = KindPress;
        else if (r < 99)  it.kind = KindRelease;
        else              it.kind = KindSpare;
        // Key for press/release: mostly from the pool or shift/ctrl
        r = $urandom_range(0, 99);
        if (r < 15)       it.key = (r < 8) ? CodeShift : CodeCtrl;
        else if (r < 75)  it.key = key_pool[$urandom_range(0, 5)];
        // Query: pool keys, or special codes, else random
        r = $urandom_range(0, 99);
        if (r < 45)       it.pdata = key_pool[$urandom_range(0, 5)];
        else if (r < 65)  it.pdata = 7'($urandom_range(CodeShift, CodeDipHi));
        transfer_item(it, 1'b0, NoOut);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (scan_reports.size() != 0) flag_mismatch("results never returned", scan_reports.size(), 0);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
